FILE: hdl/swg_pkg.sv
package swg_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int SINE_ITER_DEF  = 16;
  localparam int ATAN_ENTRIES   = 24;

  // Operand and product widths of the shift-add multiplier.
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic signed [MUL_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] MODE_PULSE  = 3'd0;
  localparam logic [2:0] MODE_STEP   = 3'd1;
  localparam logic [2:0] MODE_RAMP   = 3'd2;
  localparam logic [2:0] MODE_SINE   = 3'd3;
  localparam logic [2:0] MODE_SQUARE = 3'd4;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_LEVEL_HIGH = 3'd1;
  localparam logic [2:0] REG_LEVEL_LOW  = 3'd2;
  localparam logic [2:0] REG_DURATION   = 3'd3;
  localparam logic [2:0] REG_GRADIENT   = 3'd4;
  localparam logic [2:0] REG_AMPLITUDE  = 3'd5;
  localparam logic [2:0] REG_PHASE_RATE = 3'd6;
  localparam logic [2:0] REG_OFFSET     = 3'd7;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PHASE,
    SEQ_ROT,
    SEQ_AMP,
    SEQ_RAMP,
    SEQ_RFIN,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Arctangent of 2^-i in 2^-32 turns.
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [31:0] r;
    if (v > $signed({{(PROD_W-31){1'b0}}, {31{1'b1}}})) begin
      r = 32'h7FFFFFFF;
    end else if (v < $signed({{(PROD_W-31){1'b1}}, {31{1'b0}}})) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/swg_mul.sv
module swg_mul
  import swg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] product,
  output unit_stat_t               stat
);

  localparam int CW = $clog2(MUL_W);

  logic signed [PROD_W-1:0] a_sh;
  logic [MUL_W-1:0]         b_sh;
  logic signed [PROD_W-1:0] acc;
  logic [CW-1:0]            cnt;
  logic                     busy;
  logic                     done;
  logic signed [PROD_W-1:0] addend;
  logic                     last;

  assign addend = b_sh[0] ? a_sh : '0;
  assign last   = (cnt == CW'(MUL_W - 1));

  // One multiplier bit per cycle; the top bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= PROD_W'(a);
      b_sh <= b;
      acc  <= '0;
    end else if (busy) begin
      acc  <= last ? acc - addend : acc + addend;
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hdl/swg_cordic.sv
module swg_cordic
  import swg_pkg::*;
#(
  parameter int SINE_ITERATIONS = SINE_ITER_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [31:0]             phase,
  output logic signed [MUL_W-1:0] sine,
  output unit_stat_t              stat
);

  localparam int ITER = (SINE_ITERATIONS < ATAN_ENTRIES) ? SINE_ITERATIONS : ATAN_ENTRIES;

  logic signed [MUL_W-1:0] x;
  logic signed [MUL_W-1:0] y;
  logic signed [MUL_W-1:0] z;
  logic                    neg;
  logic [4:0]              cnt;
  logic                    busy;
  logic                    done;
  logic [31:0]             folded;
  logic                    fold;
  logic signed [MUL_W-1:0] dx;
  logic signed [MUL_W-1:0] dy;
  logic signed [MUL_W-1:0] ang;

  // Phases in the left half plane are turned by half a turn and negated.
  assign fold   = phase[31] ^ phase[30];
  assign folded = fold ? phase + 32'h80000000 : phase;
  assign dx     = y >>> cnt;
  assign dy     = x >>> cnt;
  assign ang    = $signed({2'b00, atan_turns(cnt)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= CORDIC_GAIN;
      y   <= '0;
      z   <= MUL_W'($signed(folded));
      neg <= fold;
    end else if (busy) begin
      if (!z[MUL_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ang;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ang;
      end
    end
  end

  assign sine      = neg ? -y : y;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hdl/setpoint_waveform_generator_unit.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata: time_us[31:0], pulse_trigger, step_high, ramp_down
// m_axis    out        tdata: setpoint[31:0]
// cfg       in         cfg_index selects the register, cfg_data is its value
//
// One item is worked on at a time. Pulse, step, square, unused modes and a ramp
// with zero gradient or zero time go from accept straight to the result. Ramp
// runs the 34-bit bit-serial multiplier, then a clamp and bound step. Sine runs
// a phase multiply, the CORDIC loop, then an amplitude multiply.
// A finished result waits in the output register while the next beat is taken.
// Reset clears the registers, the waveform state and the sequencer.
module setpoint_waveform_generator_unit
  import swg_pkg::*;
#(
  parameter int TIME_WIDTH      = TIME_WIDTH_DEF,
  parameter int SINE_ITERATIONS = SINE_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // time_us[31:0], pulse_trigger, step_high, ramp_down, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // setpoint[31:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TW = TIME_WIDTH;
  localparam int CW = (TW > 32) ? TW : 32;
  localparam int EW = (TW > 33) ? TW : 33;
  localparam int RW = 44;

  logic [2:0]  mode;
  logic [31:0] level_high;
  logic [31:0] level_low;
  logic [31:0] duration_us;
  logic [31:0] ramp_gradient;
  logic [31:0] sine_amplitude;
  logic [31:0] sine_phase_rate;
  logic [31:0] sine_offset;

  logic [TW-1:0] pulse_start;
  logic          ramp_prev_dir;
  logic [TW-1:0] ramp_start;
  logic [TW-1:0] square_last_toggle;
  logic          square_level;

  seq_state_t state;
  seq_state_t state_next;

  logic [31:0]          res;
  logic signed [RW-1:0] ramp_prod;
  logic                 ramp_dir;

  logic                     mul_start;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  unit_stat_t               mul_st;
  logic                     cor_start;
  logic signed [MUL_W-1:0]  cor_sine;
  unit_stat_t               cor_st;

  logic          accept;
  logic [TW-1:0] t_in;
  logic          trig;
  logic          step_hi;
  logic          down;
  logic [TW-1:0] pulse_st_new;
  logic [TW-1:0] pulse_el;
  logic [TW-1:0] ramp_st_new;
  logic [TW-1:0] ramp_el;
  logic [EW-1:0] ramp_e;
  logic [TW-1:0] sq_el;
  logic          sq_flip;
  logic          out_free;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign t_in      = TW'(s_axis_tdata[31:0]);
  assign trig      = s_axis_tdata[32];
  assign step_hi   = s_axis_tdata[33];
  assign down      = s_axis_tdata[34];
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  assign pulse_st_new = trig ? t_in : pulse_start;
  assign pulse_el     = t_in - pulse_st_new;
  assign ramp_st_new  = (down != ramp_prev_dir) ? t_in : ramp_start;
  assign ramp_el      = t_in - ramp_st_new;
  // Elapsed ramp time is capped at 2^32 ahead of the product.
  assign ramp_e = (EW'(ramp_el) > (EW'(1) << 32)) ? (EW'(1) << 32) : EW'(ramp_el);
  assign sq_el   = t_in - square_last_toggle;
  assign sq_flip = CW'(sq_el) > CW'(duration_us);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= '0;
      level_high      <= '0;
      level_low       <= '0;
      duration_us     <= '0;
      ramp_gradient   <= '0;
      sine_amplitude  <= '0;
      sine_phase_rate <= '0;
      sine_offset     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:       mode            <= cfg_data[2:0];
        REG_LEVEL_HIGH: level_high      <= cfg_data;
        REG_LEVEL_LOW:  level_low       <= cfg_data;
        REG_DURATION:   duration_us     <= cfg_data;
        REG_GRADIENT:   ramp_gradient   <= cfg_data;
        REG_AMPLITUDE:  sine_amplitude  <= cfg_data;
        REG_PHASE_RATE: sine_phase_rate <= cfg_data;
        REG_OFFSET:     sine_offset     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_start        <= '0;
      ramp_prev_dir      <= 1'b0;
      ramp_start         <= '0;
      square_last_toggle <= '0;
      square_level       <= 1'b0;
    end else if (accept) begin
      case (mode)
        MODE_PULSE: pulse_start <= pulse_st_new;
        MODE_RAMP: begin
          ramp_prev_dir <= down;
          ramp_start    <= ramp_st_new;
        end
        MODE_SQUARE: begin
          if (sq_flip) begin
            square_last_toggle <= t_in;
            square_level       <= ~square_level;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (accept) begin
          if (mode == MODE_SINE) begin
            state_next = SEQ_PHASE;
          end else if (mode == MODE_RAMP && ramp_gradient != '0 && t_in != '0) begin
            state_next = SEQ_RAMP;
          end else begin
            state_next = SEQ_DONE;
          end
        end
      end
      SEQ_PHASE: if (mul_st.done) state_next = SEQ_ROT;
      SEQ_ROT:   if (cor_st.done) state_next = SEQ_AMP;
      SEQ_AMP:   if (mul_st.done) state_next = SEQ_DONE;
      SEQ_RAMP:  if (mul_st.done) state_next = SEQ_RFIN;
      SEQ_RFIN:  state_next = SEQ_DONE;
      SEQ_DONE:  if (out_free) state_next = SEQ_IDLE;
      default:   state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    cor_start     = 1'b0;
    mul_a         = $signed({2'b00, sine_phase_rate});
    mul_b         = $signed(MUL_W'(t_in));
    case (state)
      SEQ_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept && mode == MODE_SINE) begin
          mul_start = 1'b1;
        end else if (accept && mode == MODE_RAMP && ramp_gradient != '0 && t_in != '0) begin
          mul_start = 1'b1;
          mul_a     = MUL_W'($signed(ramp_gradient));
          mul_b     = $signed({1'b0, ramp_e[32:0]});
        end
      end
      SEQ_PHASE: cor_start = mul_st.done;
      SEQ_ROT: begin
        mul_start = cor_st.done;
        mul_a     = MUL_W'($signed(sine_amplitude));
        mul_b     = cor_sine;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= SEQ_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == SEQ_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result datapath; the clamped ramp product is registered, then bounded in a state of its own.
  logic signed [PROD_W-1:0] sine_sum;
  logic signed [PROD_W-1:0] ramp_clamp;
  logic signed [RW-1:0]     ramp_v;
  logic signed [RW-1:0]     hi_r;
  logic signed [RW-1:0]     lo_r;

  assign sine_sum = ((mul_p + (PROD_W'(1) <<< 29)) >>> 30) + PROD_W'($signed(sine_offset));
  assign ramp_clamp = (mul_p > (PROD_W'(1) <<< 40)) ? (PROD_W'(1) <<< 40) :
                      (mul_p < -(PROD_W'(1) <<< 40)) ? -(PROD_W'(1) <<< 40) : mul_p;
  assign hi_r = RW'($signed(level_high));
  assign lo_r = RW'($signed(level_low));
  always_comb begin
    if (!ramp_dir) begin
      ramp_v = lo_r + ramp_prod;
      if (ramp_v > hi_r) ramp_v = hi_r;
    end else begin
      ramp_v = hi_r - ramp_prod;
      if (ramp_v < lo_r) ramp_v = lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state == SEQ_IDLE && accept) begin
      ramp_dir <= down;
      case (mode)
        MODE_PULSE:
          res <= (CW'(pulse_el) < CW'(duration_us)) ? level_high : level_low;
        MODE_STEP:   res <= step_hi ? level_high : level_low;
        MODE_SQUARE: res <= (square_level ^ sq_flip) ? level_high : level_low;
        default:     res <= '0;
      endcase
    end else if (state == SEQ_AMP && mul_st.done) begin
      res <= sat32(sine_sum);
    end else if (state == SEQ_RAMP && mul_st.done) begin
      ramp_prod <= RW'(ramp_clamp);
    end else if (state == SEQ_RFIN) begin
      res <= sat32(PROD_W'(ramp_v));
    end
    if (state == SEQ_DONE && out_free) begin
      m_axis_tdata <= res;
    end
  end

  swg_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .stat    (mul_st)
  );

  swg_cordic #(
    .SINE_ITERATIONS (SINE_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .phase (mul_p[31:0]),
    .sine  (cor_sine),
    .stat  (cor_st)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in flight");
  a_units_apart: assert property (@(posedge clk) disable iff (rst)
    !(mul_st.busy && cor_st.busy))
    else $error("multiplier and rotator busy together");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid ##1 m_axis_tvalid) |-> $past(state == SEQ_DONE))
    else $error("result shown without a finished item");
`endif

endmodule
